// File: rtl/core/spsr_pkg.sv
// ----------------------------------------------------------------------------
// spsr_pkg: shared types and constants of the packet sequence resync block
// Holds the verdict codes, header constants, register indexes and the
// structs that pass an item, its result and the tracking state between files.
// ----------------------------------------------------------------------------
package spsr_pkg;

  // Header constants.
  localparam logic [15:0] HDR_BYTES     = 16'd16;
  localparam logic [15:0] NO_SYNC       = 16'hFFFF;
  localparam int unsigned FLAG_KEY_BIT  = 0;
  localparam int unsigned FLAG_EOS_BIT  = 1;

  // Register reset values.
  localparam logic [31:0] MAGIC_RESET   = 32'h4C425331;
  localparam logic [7:0]  VERSION_RESET = 8'd1;

  // Register indexes, taken from byte address bit 2.
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  // Verdict codes.
  typedef enum logic [3:0] {
    VERDICT_FWD     = 4'd0,
    VERDICT_SHORT   = 4'd1,
    VERDICT_MAGIC   = 4'd2,
    VERDICT_VERSION = 4'd3,
    VERDICT_HDRSIZE = 4'd4,
    VERDICT_LEN     = 4'd5,
    VERDICT_OLD     = 4'd6,
    VERDICT_SKIP    = 4'd7,
    VERDICT_BADSYNC = 4'd8,
    VERDICT_EMPTY   = 4'd9
  } verdict_t;

  // One input item.
  typedef struct packed {
    logic [15:0] datagram_len;
    logic [31:0] magic_word;
    logic [7:0]  version_byte;
    logic [7:0]  flag_bits;
    logic [15:0] hdr_size;
    logic [31:0] packet_seq;
    logic [15:0] payload_len;
    logic [15:0] resync_pos;
  } spsr_item_t;

  // One result item.
  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] chunk_start;
    logic [15:0] chunk_len;
    logic [31:0] lost_now;
    logic [31:0] packet_count;
    logic [31:0] lost_count;
    logic [31:0] chunk_count;
    logic        awaiting_keyframe;
  } spsr_result_t;

  // Sequence tracking state and counters.
  typedef struct packed {
    logic        seq_known;
    logic [31:0] next_seq;
    logic        waiting_sync;
    logic [31:0] packets_total;
    logic [31:0] packets_lost;
    logic [31:0] chunks_total;
  } spsr_state_t;

  // Saturating 32-bit add.
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

// File: rtl/core/spsr_eval.sv
// ----------------------------------------------------------------------------
// spsr_eval: header check and sequence decision for one item
// Combinational: validates the header, compares the sequence number with the
// expected one, picks the verdict and payload slice and forms the next state.
// ----------------------------------------------------------------------------
module spsr_eval
  import spsr_pkg::*;
(
  input  spsr_item_t   item,
  input  logic [31:0]  exp_magic,
  input  logic [7:0]   exp_version,
  input  spsr_state_t  st,
  output spsr_result_t res,
  output spsr_state_t  st_nxt
);

  logic        len_short;
  logic [15:0] room;
  logic        hdr_ok;
  logic [31:0] ref_seq;
  logic [32:0] diff;
  logic        is_old;
  logic        is_gap;
  logic [31:0] lost;
  logic        wait_eff;
  logic [15:0] off;
  logic        key;
  logic        eos;
  logic        off_bad;
  verdict_t    seq_verdict;
  verdict_t    verdict;

  // Header checks in their fixed order.
  assign len_short = item.datagram_len < HDR_BYTES;
  assign room      = item.datagram_len - HDR_BYTES;

  always_comb begin
    hdr_ok = 1'b0;
    if (len_short) begin
      verdict = VERDICT_SHORT;
    end else if (item.magic_word != exp_magic) begin
      verdict = VERDICT_MAGIC;
    end else if (item.version_byte != exp_version) begin
      verdict = VERDICT_VERSION;
    end else if (item.hdr_size != HDR_BYTES) begin
      verdict = VERDICT_HDRSIZE;
    end else if (item.payload_len > room) begin
      verdict = VERDICT_LEN;
    end else begin
      verdict = seq_verdict;
      hdr_ok  = 1'b1;
    end
  end

  // The first valid packet sets the expected sequence to its own number.
  assign ref_seq  = st.seq_known ? st.next_seq : item.packet_seq;
  assign diff     = {1'b0, item.packet_seq} - {1'b0, ref_seq};
  assign is_old   = diff[32];
  assign is_gap   = !is_old && (diff[31:0] != 32'd0);
  assign lost     = is_gap ? diff[31:0] : 32'd0;
  assign wait_eff = !st.seq_known || st.waiting_sync || is_gap;

  assign off     = (item.resync_pos == NO_SYNC) ? 16'd0 : item.resync_pos;
  assign key     = item.flag_bits[FLAG_KEY_BIT];
  assign eos     = item.flag_bits[FLAG_EOS_BIT];
  assign off_bad = off >= item.payload_len;

  // Sequence verdict for a packet whose header passed.
  always_comb begin
    if (is_old) begin
      seq_verdict = VERDICT_OLD;
    end else if (wait_eff && !key) begin
      seq_verdict = VERDICT_SKIP;
    end else if (wait_eff && off_bad) begin
      seq_verdict = VERDICT_BADSYNC;
    end else if (!wait_eff && (item.payload_len == 16'd0)) begin
      seq_verdict = VERDICT_EMPTY;
    end else begin
      seq_verdict = VERDICT_FWD;
    end
  end

  // Next tracking state; a rejected header leaves everything untouched.
  always_comb begin
    st_nxt = st;
    if (hdr_ok) begin
      st_nxt.packets_total = sat_add32(st.packets_total, 32'd1);
      st_nxt.seq_known     = 1'b1;
      if (!is_old) begin
        st_nxt.next_seq     = item.packet_seq + 32'd1;
        st_nxt.packets_lost = sat_add32(st.packets_lost, lost);
        if (seq_verdict == VERDICT_FWD) begin
          st_nxt.chunks_total = sat_add32(st.chunks_total, 32'd1);
        end
        if ((seq_verdict == VERDICT_SKIP) || (seq_verdict == VERDICT_BADSYNC)) begin
          st_nxt.waiting_sync = 1'b1;
        end else if (wait_eff) begin
          st_nxt.waiting_sync = eos;
        end else begin
          st_nxt.waiting_sync = eos;
        end
      end
    end
  end

  // Result fields, counters taken after the update.
  always_comb begin
    res.verdict           = verdict;
    res.chunk_start       = 16'd0;
    res.chunk_len         = 16'd0;
    res.lost_now          = hdr_ok ? lost : 32'd0;
    res.packet_count      = st_nxt.packets_total;
    res.lost_count        = st_nxt.packets_lost;
    res.chunk_count       = st_nxt.chunks_total;
    res.awaiting_keyframe = st_nxt.waiting_sync;
    if (verdict == VERDICT_FWD) begin
      res.chunk_start = wait_eff ? off : 16'd0;
      res.chunk_len   = wait_eff ? (item.payload_len - off) : item.payload_len;
    end
  end

endmodule

// File: rtl/core/stream_packet_seq_resync.sv
// ----------------------------------------------------------------------------
// stream_packet_seq_resync: datagram header check and sequence resync
// Top level with the input register, result register, tracking state and
// the APB-style register port.
// ----------------------------------------------------------------------------
// The block accepts one datagram item in every cycle while the result channel
// does not stall, and returns one result item for each. An accepted item is
// held in the input register until the result register is free, then its
// result passes through the single-pass decision logic into the result
// register and is offered; the tracking state is updated at that edge so the
// next item sees it. A stalled result holds in the result register while one
// more item waits in the input register. No clearing pass follows reset.
module stream_packet_seq_resync
  import spsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_datagram_len,
  input  logic [31:0] in_magic_word,
  input  logic [7:0]  in_version_byte,
  input  logic [7:0]  in_flag_bits,
  input  logic [15:0] in_hdr_size,
  input  logic [31:0] in_packet_seq,
  input  logic [15:0] in_payload_len,
  input  logic [15:0] in_resync_pos,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_verdict,
  output logic [15:0] out_chunk_start,
  output logic [15:0] out_chunk_len,
  output logic [31:0] out_lost_now,
  output logic [31:0] out_packet_count,
  output logic [31:0] out_lost_count,
  output logic [31:0] out_chunk_count,
  output logic        out_awaiting_keyframe,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic         in_valid_r, in_valid_nxt;
  spsr_item_t   item_r;
  logic         out_valid_r, out_valid_nxt;
  spsr_result_t res_r;
  spsr_result_t res;
  spsr_state_t  st_r, st_nxt;
  logic [31:0]  magic_r;
  logic [7:0]   version_r;
  logic         advance;
  logic         in_take;
  logic         cfg_wr;

  // Handshake: the result register frees when empty or taken.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = advance ? in_valid_r : out_valid_r;

  // Register port: always ready, index from address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_MAGIC:   prdata = magic_r;
      REG_VERSION: prdata = {24'd0, version_r};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_RESET;
      version_r <= VERSION_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAGIC:   magic_r   <= pwdata;
        REG_VERSION: version_r <= pwdata[7:0];
        default:     magic_r   <= magic_r;
      endcase
    end
  end

  // Decision logic between input and result registers.
  spsr_eval u_eval (
    .item        (item_r),
    .exp_magic   (magic_r),
    .exp_version (version_r),
    .st          (st_r),
    .res         (res),
    .st_nxt      (st_nxt)
  );

  // Control and tracking state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      st_r.seq_known     <= 1'b0;
      st_r.next_seq      <= 32'd0;
      st_r.waiting_sync  <= 1'b1;
      st_r.packets_total <= 32'd0;
      st_r.packets_lost  <= 32'd0;
      st_r.chunks_total  <= 32'd0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_valid_r && advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.datagram_len <= in_datagram_len;
      item_r.magic_word   <= in_magic_word;
      item_r.version_byte <= in_version_byte;
      item_r.flag_bits    <= in_flag_bits;
      item_r.hdr_size     <= in_hdr_size;
      item_r.packet_seq   <= in_packet_seq;
      item_r.payload_len  <= in_payload_len;
      item_r.resync_pos   <= in_resync_pos;
    end
    if (in_valid_r && advance) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_verdict           = res_r.verdict;
  assign out_chunk_start       = res_r.chunk_start;
  assign out_chunk_len         = res_r.chunk_len;
  assign out_lost_now          = res_r.lost_now;
  assign out_packet_count      = res_r.packet_count;
  assign out_lost_count        = res_r.lost_count;
  assign out_chunk_count       = res_r.chunk_count;
  assign out_awaiting_keyframe = res_r.awaiting_keyframe;

`ifndef SYNTHESIS
  // Only a forwarded item carries a payload slice.
  a_slice_only_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.verdict != VERDICT_FWD) |-> (res_r.chunk_len == 16'd0))
    else $error("payload slice on an item that was not forwarded");

  // A forwarded item always leaves a nonzero chunk count.
  a_fwd_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.verdict == VERDICT_FWD) |-> (res_r.chunk_count != 32'd0))
    else $error("forwarded item without a chunk count");

  // The packet counter never goes backward.
  a_pkt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (st_r.packets_total >= $past(st_r.packets_total)))
    else $error("packet counter decreased");

  // The input side stalls only while an item waits in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with nothing waiting");
`endif

endmodule

// File: tb/tb_stream_packet_seq_resync.sv
// ----------------------------------------------------------------------------
// tb_stream_packet_seq_resync: self-checking bench for the packet resync block
// Sends datagram header items through the valid/stall input channel, predicts
// every verdict and counter in the bench, and compares each result item field
// by field. Both channels idle at random, and the magic and version registers
// are rewritten between traffic phases, including their extreme values.
// ----------------------------------------------------------------------------
module tb_stream_packet_seq_resync;
  import spsr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [7:0]  F_KEY       = 8'(1 << FLAG_KEY_BIT);
  localparam logic [7:0]  F_EOS       = 8'(1 << FLAG_EOS_BIT);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_datagram_len = '0;
  logic [31:0] in_magic_word = '0;
  logic [7:0]  in_version_byte = '0;
  logic [7:0]  in_flag_bits = '0;
  logic [15:0] in_hdr_size = '0;
  logic [31:0] in_packet_seq = '0;
  logic [15:0] in_payload_len = '0;
  logic [15:0] in_resync_pos = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_verdict;
  logic [15:0] out_chunk_start;
  logic [15:0] out_chunk_len;
  logic [31:0] out_lost_now;
  logic [31:0] out_packet_count;
  logic [31:0] out_lost_count;
  logic [31:0] out_chunk_count;
  logic        out_awaiting_keyframe;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Register copies and tracking state of the prediction.
  logic [31:0]  cfg_magic = MAGIC_RESET;
  logic [7:0]   cfg_version = VERSION_RESET;
  spsr_state_t  trk = '{seq_known: 1'b0, next_seq: 32'd0, waiting_sync: 1'b1,
                        packets_total: 32'd0, packets_lost: 32'd0,
                        chunks_total: 32'd0};

  spsr_item_t   datagram_queue [$];
  spsr_result_t owed_verdicts [$];
  spsr_item_t   cur_item;
  logic [31:0]  gen_seq = 32'd0;

  int unsigned  tx_gap = 0;
  int unsigned  rx_gap = 0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;
  int unsigned  cycle_count = 0;
  int unsigned  datagrams_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  settings_run = 1;
  int unsigned  verdict_seen [10];

  stream_packet_seq_resync uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_datagram_len       (in_datagram_len),
    .in_magic_word         (in_magic_word),
    .in_version_byte       (in_version_byte),
    .in_flag_bits          (in_flag_bits),
    .in_hdr_size           (in_hdr_size),
    .in_packet_seq         (in_packet_seq),
    .in_payload_len        (in_payload_len),
    .in_resync_pos         (in_resync_pos),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_verdict           (out_verdict),
    .out_chunk_start       (out_chunk_start),
    .out_chunk_len         (out_chunk_len),
    .out_lost_now          (out_lost_now),
    .out_packet_count      (out_packet_count),
    .out_lost_count        (out_lost_count),
    .out_chunk_count       (out_chunk_count),
    .out_awaiting_keyframe (out_awaiting_keyframe),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always #4 clk = ~clk;

  // Counter that sticks at all ones instead of wrapping.
  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Decide the verdict for one datagram and advance the tracking state.
  function automatic spsr_result_t judge_datagram(input spsr_item_t it);
    spsr_result_t r;
    logic [15:0]  off;
    logic         done;
    r = '0;
    r.verdict = VERDICT_FWD;
    if (it.datagram_len < HDR_BYTES) begin
      r.verdict = VERDICT_SHORT;
    end else if (it.magic_word != cfg_magic) begin
      r.verdict = VERDICT_MAGIC;
    end else if (it.version_byte != cfg_version) begin
      r.verdict = VERDICT_VERSION;
    end else if (it.hdr_size != HDR_BYTES) begin
      r.verdict = VERDICT_HDRSIZE;
    end else if (it.payload_len > it.datagram_len - HDR_BYTES) begin
      r.verdict = VERDICT_LEN;
    end else begin
      trk.packets_total = sat_sum(trk.packets_total, 32'd1);
      // The first good header defines where the sequence starts.
      if (!trk.seq_known) begin
        trk.seq_known    = 1'b1;
        trk.next_seq     = it.packet_seq;
        trk.waiting_sync = 1'b1;
      end
      if (it.packet_seq < trk.next_seq) begin
        r.verdict = VERDICT_OLD;
      end else begin
        done = 1'b1;
        if (it.packet_seq > trk.next_seq) begin
          r.lost_now       = it.packet_seq - trk.next_seq;
          trk.packets_lost = sat_sum(trk.packets_lost, r.lost_now);
          trk.waiting_sync = 1'b1;
        end
        if (trk.waiting_sync) begin
          off = (it.resync_pos == NO_SYNC) ? 16'd0 : it.resync_pos;
          if (!it.flag_bits[FLAG_KEY_BIT]) begin
            r.verdict = VERDICT_SKIP;
            done      = 1'b0;
          end else if (off >= it.payload_len) begin
            r.verdict = VERDICT_BADSYNC;
            done      = 1'b0;
          end else begin
            r.chunk_start    = off;
            r.chunk_len      = it.payload_len - off;
            trk.chunks_total = sat_sum(trk.chunks_total, 32'd1);
            trk.waiting_sync = 1'b0;
          end
        end else if (it.payload_len == 16'd0) begin
          r.verdict = VERDICT_EMPTY;
        end else begin
          r.chunk_len      = it.payload_len;
          trk.chunks_total = sat_sum(trk.chunks_total, 32'd1);
        end
        trk.next_seq = it.packet_seq + 32'd1;
        // End of stream only takes effect once the packet was handled.
        if (done && it.flag_bits[FLAG_EOS_BIT]) trk.waiting_sync = 1'b1;
      end
    end
    r.packet_count      = trk.packets_total;
    r.lost_count        = trk.packets_lost;
    r.chunk_count       = trk.chunks_total;
    r.awaiting_keyframe = trk.waiting_sync;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("MISMATCH result %0d %s: got 0x%08h, expected 0x%08h",
               results_seen, field, got, want);
  endtask

  // Compare one result item with the oldest prediction.
  task automatic check_result(input spsr_result_t got);
    spsr_result_t want;
    if (owed_verdicts.size() == 0) begin
      report_mismatch("result with nothing outstanding", 32'(got.verdict), 32'd0);
      return;
    end
    want = owed_verdicts.pop_front();
    if (got.verdict !== want.verdict)
      report_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
    if (got.chunk_start !== want.chunk_start)
      report_mismatch("chunk_start", 32'(got.chunk_start), 32'(want.chunk_start));
    if (got.chunk_len !== want.chunk_len)
      report_mismatch("chunk_len", 32'(got.chunk_len), 32'(want.chunk_len));
    if (got.lost_now !== want.lost_now)
      report_mismatch("lost_now", got.lost_now, want.lost_now);
    if (got.packet_count !== want.packet_count)
      report_mismatch("packet_count", got.packet_count, want.packet_count);
    if (got.lost_count !== want.lost_count)
      report_mismatch("lost_count", got.lost_count, want.lost_count);
    if (got.chunk_count !== want.chunk_count)
      report_mismatch("chunk_count", got.chunk_count, want.chunk_count);
    if (got.awaiting_keyframe !== want.awaiting_keyframe)
      report_mismatch("awaiting_keyframe", 32'(got.awaiting_keyframe),
                      32'(want.awaiting_keyframe));
  endtask

  task automatic push_dg(input logic [15:0] dlen, input logic [31:0] magic,
                         input logic [7:0] ver, input logic [7:0] flags,
                         input logic [15:0] hsz, input logic [31:0] seq,
                         input logic [15:0] plen, input logic [15:0] sync);
    spsr_item_t it;
    it.datagram_len = dlen;
    it.magic_word   = magic;
    it.version_byte = ver;
    it.flag_bits    = flags;
    it.hdr_size     = hsz;
    it.packet_seq   = seq;
    it.payload_len  = plen;
    it.resync_pos   = sync;
    datagram_queue.push_back(it);
  endtask

  // Mostly well-formed traffic in sequence, with gaps, stale packets and
  // corrupted headers mixed in.
  task automatic queue_random_datagrams(input int count);
    spsr_item_t     it;
    int unsigned    kind;
    int unsigned    roll;
    int unsigned    plen;
    int unsigned    extra;
    logic [159:0]   noise;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      roll = $urandom_range(0, 9);
      if (roll < 2) plen = 0;
      else if (roll < 9) plen = $urandom_range(1, 64);
      else plen = $urandom_range(0, 65519);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65519 - plen) : 0;
      it.payload_len  = 16'(plen);
      it.datagram_len = HDR_BYTES + 16'(plen + extra);
      it.magic_word   = cfg_magic;
      it.version_byte = cfg_version;
      it.hdr_size     = HDR_BYTES;
      it.flag_bits    = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) != 0) it.flag_bits[FLAG_EOS_BIT] = 1'b0;
      roll = $urandom_range(0, 9);
      if (roll < 4) it.resync_pos = NO_SYNC;
      else if (roll < 7) it.resync_pos = (plen == 0) ? 16'd0 : 16'($urandom_range(0, plen - 1));
      else if (roll == 7) it.resync_pos = 16'(plen);
      else it.resync_pos = 16'($urandom_range(0, 65535));
      it.packet_seq = gen_seq;
      if (kind >= 70 && kind < 80) begin
        // Forward jump: small gap, anywhere, or right below the wrap point.
        roll = $urandom_range(0, 9);
        if (roll < 6) it.packet_seq = gen_seq + $urandom_range(1, 20);
        else if (roll < 9) it.packet_seq = $urandom;
        else it.packet_seq = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end else if (kind >= 80 && kind < 86) begin
        it.packet_seq = gen_seq - $urandom_range(1, 4);
      end else if (kind >= 86) begin
        case ($urandom_range(0, 5))
          0: it.datagram_len = 16'($urandom_range(0, 15));
          1: it.magic_word = $urandom;
          2: it.version_byte = 8'($urandom_range(0, 255));
          3: it.hdr_size = 16'($urandom_range(0, 65535));
          4: begin
            it.datagram_len = HDR_BYTES + 16'($urandom_range(0, 100));
            it.payload_len  = it.datagram_len - HDR_BYTES + 16'($urandom_range(1, 50));
          end
          default: begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
            it = noise[143:0];
          end
        endcase
      end
      if (kind < 80) gen_seq = it.packet_seq + 32'd1;
      datagram_queue.push_back(it);
    end
  endtask

  // Write a register, then read it back.
  task automatic write_register(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MAGIC) cfg_magic = value;
    else cfg_version = value[7:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (idx == REG_MAGIC && prdata !== cfg_magic)
      report_mismatch("magic register readback", prdata, cfg_magic);
    if (idx == REG_VERSION && prdata[7:0] !== cfg_version)
      report_mismatch("version register readback", 32'(prdata[7:0]), 32'(cfg_version));
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block is idle once every queued item went in and every result came out.
  task automatic wait_idle();
    do @(negedge clk);
    while (datagram_queue.size() != 0 || in_valid || owed_verdicts.size() != 0);
  endtask

  // Input side: predict on acceptance, then present the next item after its gap.
  always @(posedge clk) begin : datagram_driver
    spsr_item_t nxt;
    logic       held;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      held = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        owed_verdicts.push_back(judge_datagram(cur_item));
        datagrams_sent++;
      end
      if (!held) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (datagram_queue.size() != 0) begin
          nxt      = datagram_queue.pop_front();
          cur_item = nxt;
          in_datagram_len <= nxt.datagram_len;
          in_magic_word   <= nxt.magic_word;
          in_version_byte <= nxt.version_byte;
          in_flag_bits    <= nxt.flag_bits;
          in_hdr_size     <= nxt.hdr_size;
          in_packet_seq   <= nxt.packet_seq;
          in_payload_len  <= nxt.payload_len;
          in_resync_pos   <= nxt.resync_pos;
          in_valid        <= 1'b1;
          if ($urandom_range(0, 47) == 0) tx_quiet = !tx_quiet;
          tx_gap = tx_quiet ? 0 : $urandom_range(0, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: check each accepted item, then stall for a random stretch.
  always @(posedge clk) begin : verdict_monitor
    spsr_result_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.verdict           = verdict_t'(out_verdict);
        got.chunk_start       = out_chunk_start;
        got.chunk_len         = out_chunk_len;
        got.lost_now          = out_lost_now;
        got.packet_count      = out_packet_count;
        got.lost_count        = out_lost_count;
        got.chunk_count       = out_chunk_count;
        got.awaiting_keyframe = out_awaiting_keyframe;
        check_result(got);
        results_seen++;
        if (out_verdict < 4'd10) verdict_seen[out_verdict]++;
        if ($urandom_range(0, 47) == 0) rx_quiet = !rx_quiet;
        rx_gap = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (rx_gap != 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, owed_verdicts.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] m;
    logic [7:0]  v;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset register values.
    m = cfg_magic;
    v = cfg_version;
    push_dg(16'd0, m, v, 8'h00, HDR_BYTES, 32'd0, 16'd0, 16'd0);
    push_dg(16'd15, m, v, F_KEY, HDR_BYTES, 32'd5, 16'd0, 16'd0);
    push_dg(16'd16, ~m, v, F_KEY, HDR_BYTES, 32'd5, 16'd0, 16'd0);
    push_dg(16'd16, m, ~v, F_KEY, HDR_BYTES, 32'd5, 16'd0, 16'd0);
    push_dg(16'd16, m, v, F_KEY, 16'hFFFF, 32'd5, 16'd0, 16'd0);
    push_dg(16'd16, m, v, F_KEY, 16'd0, 32'd5, 16'd0, 16'd0);
    push_dg(16'd20, m, v, F_KEY, HDR_BYTES, 32'd5, 16'd5, 16'd0);
    push_dg(16'hFFFF, m, v, F_KEY, HDR_BYTES, 32'd5, 16'hFFFF, 16'd0);
    // First good packet without a keyframe, then the resync on a keyframe.
    push_dg(16'd26, m, v, 8'h00, HDR_BYTES, 32'd100, 16'd10, 16'd0);
    push_dg(16'd26, m, v, F_KEY, HDR_BYTES, 32'd101, 16'd10, NO_SYNC);
    push_dg(16'd16, m, v, 8'h00, HDR_BYTES, 32'd102, 16'd0, 16'd0);
    push_dg(16'hFFFF, m, v, 8'h00, HDR_BYTES, 32'd103, 16'd65519, 16'd0);
    // Stale and duplicate packets.
    push_dg(16'd30, m, v, F_KEY, HDR_BYTES, 32'd100, 16'd4, 16'd0);
    push_dg(16'd30, m, v, 8'h00, HDR_BYTES, 32'd103, 16'd4, 16'd0);
    // Gap with sync offsets at and just inside the payload end.
    push_dg(16'd21, m, v, F_KEY, HDR_BYTES, 32'd110, 16'd5, 16'd5);
    push_dg(16'd21, m, v, F_KEY | F_EOS, HDR_BYTES, 32'd111, 16'd5, 16'd5);
    push_dg(16'd21, m, v, F_KEY, HDR_BYTES, 32'd112, 16'd5, 16'd4);
    push_dg(16'd19, m, v, F_EOS, HDR_BYTES, 32'd113, 16'd3, 16'd0);
    push_dg(16'd19, m, v, 8'hFC, HDR_BYTES, 32'd114, 16'd3, 16'd0);
    // Sequence wrap, then a loss large enough to saturate the lost counter.
    push_dg(16'd17, m, v, F_KEY, HDR_BYTES, 32'hFFFF_FFFF, 16'd1, 16'd0);
    push_dg(16'd17, m, v, 8'h00, HDR_BYTES, 32'd0, 16'd1, 16'd0);
    push_dg(16'd16, m, v, F_EOS, HDR_BYTES, 32'd1, 16'd0, 16'd0);
    push_dg(16'd18, m, v, F_KEY, HDR_BYTES, 32'hFFFF_FFF0, 16'd2, 16'hFFFE);
    push_dg(16'd18, m, v, 8'hFF, HDR_BYTES, 32'hFFFF_FFF1, 16'd2, 16'd1);
    gen_seq = 32'hFFFF_FFF2;
    queue_random_datagrams(250);
    wait_idle();

    // Further register settings: all zeros, all ones, random, back to reset.
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: begin m = 32'd0; v = 8'd0; end
        1: begin m = 32'hFFFF_FFFF; v = 8'hFF; end
        2: begin m = $urandom; v = 8'($urandom_range(0, 255)); end
        default: begin m = MAGIC_RESET; v = VERSION_RESET; end
      endcase
      write_register(REG_MAGIC, m);
      write_register(REG_VERSION, {24'd0, v});
      settings_run++;
      queue_random_datagrams(190);
      wait_idle();
    end
    repeat (8) @(posedge clk);

    $display("covered %0d items over %0d register settings: %0d forwarded, %0d empty, %0d old",
             datagrams_sent, settings_run, verdict_seen[VERDICT_FWD],
             verdict_seen[VERDICT_EMPTY], verdict_seen[VERDICT_OLD]);
    $display("  %0d skipped, %0d bad sync, %0d header rejects; %0d mismatches",
             verdict_seen[VERDICT_SKIP], verdict_seen[VERDICT_BADSYNC],
             verdict_seen[VERDICT_SHORT] + verdict_seen[VERDICT_MAGIC] +
             verdict_seen[VERDICT_VERSION] + verdict_seen[VERDICT_HDRSIZE] +
             verdict_seen[VERDICT_LEN], mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: stream_packet_seq_resync.f
rtl/core/spsr_pkg.sv
rtl/core/spsr_eval.sv
rtl/core/stream_packet_seq_resync.sv
tb/tb_stream_packet_seq_resync.sv
